// ===== hdl/imh_pkg.sv =====
`timescale 1ns / 1ps
// Package for the indexed min-heap: request/status codes, payload structs, FSM state codes,
// default sizes. No dependencies.
package imh_pkg;

  localparam int unsigned MaxItemsDef = 256;
  localparam int unsigned KeyBitsDef  = 32;
  localparam int unsigned IdBits      = 8;
  localparam int unsigned IdSpace     = 1 << IdBits;
  localparam int unsigned PosBits     = 9;
  localparam int unsigned OutKeyBits  = 32;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_REMOVE  = 2'd2,
    REQ_QUERY   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_PRESENT = 3'd3,
    ST_ABSENT  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [IdBits-1:0]     item_id;
    logic [OutKeyBits-1:0] item_key;
  } req_t;

  typedef struct packed {
    logic [IdBits-1:0]     out_id;
    logic [OutKeyBits-1:0] out_key;
    logic [PosBits-1:0]    out_position;
    logic [PosBits-1:0]    entry_count;
    logic [2:0]            status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_UP_RD,
    S_UP_CMP,
    S_UP_WR,
    S_TOP_RD,
    S_TOP_SWAP,
    S_TOP_CLR,
    S_DN_RD,
    S_DN_CMP,
    S_DN_RD2,
    S_DN_SWAP,
    S_DN_WR,
    S_DONE
  } state_e;

endpackage

// ===== hdl/imh_pos_map.sv =====
`timescale 1ns / 1ps
// Id-to-slot map: one synchronous memory with a valid bit per id.
// Depends on imh_pkg.
module imh_pos_map import imh_pkg::*; #(
  parameter int unsigned PosW = PosBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IdBits-1:0] rd_id_i,
  output logic [PosW-1:0]   rd_pos_o,
  input  logic              wr_en_i,
  input  logic [IdBits-1:0] wr_id_i,
  input  logic [PosW-1:0]   wr_pos_i
);

  logic [PosW-1:0]    mem [IdSpace];
  logic [IdSpace-1:0] vld_q;
  logic [PosW-1:0]    rdat_q;
  logic               rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_id_i] <= wr_pos_i;
    end
    rdat_q <= mem[rd_id_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_id_i] <= 1'b1;
      end
      rvld_q <= vld_q[rd_id_i];
    end
  end

  assign rd_pos_o = rvld_q ? rdat_q : '0;

endmodule

// ===== hdl/imh_slot_mem.sv =====
`timescale 1ns / 1ps
// Heap slot store: (id, key) per slot, one write and two read ports.
// Depends on imh_pkg.
module imh_slot_mem import imh_pkg::*; #(
  parameter int unsigned Depth = MaxItemsDef,
  parameter int unsigned KeyW  = KeyBitsDef,
  parameter int unsigned AddrW = 8
) (
  input  logic                   clk_i,
  input  logic [AddrW-1:0]       ra_i,
  input  logic [AddrW-1:0]       rb_i,
  output logic [IdBits+KeyW-1:0] da_o,
  output logic [IdBits+KeyW-1:0] db_o,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       wa_i,
  input  logic [IdBits+KeyW-1:0] wd_i
);

  logic [IdBits+KeyW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    da_o <= mem[ra_i];
    db_o <= mem[rb_i];
  end

endmodule

// ===== hdl/indexed_min_heap.sv =====
`timescale 1ns / 1ps
// Indexed binary min-heap, one transaction at a time.
// A query or rejected request goes through lookup and done only; per level, sift-up and the
// remove walk-up read, compare and write, and sift-down reads, compares, reads the right
// child when there is one, swaps and writes. The result becomes valid in the same cycle as
// the input is ready again; a stalled result lets the next transaction run to done and wait there.
// Reset: asynchronous; clears state, count, output valid and the id map valid bits.
module indexed_min_heap import imh_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDef,
  parameter int unsigned KEY_BITS  = KeyBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AddrW = $clog2(MAX_ITEMS);
  localparam int unsigned EntW  = IdBits + KEY_BITS;

  state_e state_q, state_d;
  req_t   req_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     i_q, i_d;      // current slot, 1-based
  logic [EntW-1:0]     ea_q, ea_d, eb_q, eb_d;
  logic [CntW-1:0]     best_q, best_d;
  status_e             st_q, st_d;
  logic [IdBits-1:0]   oid_q, oid_d;
  logic [KEY_BITS-1:0] okey_q, okey_d;
  logic [CntW-1:0]     opos_q, opos_d;
  logic                out_valid_q;
  rsp_t                out_q;

  // memory ports
  logic [AddrW-1:0]  ra, rb, wa;
  logic [EntW-1:0]   da, db, wd;
  logic              we;
  logic [IdBits-1:0] pm_wid;
  logic [CntW-1:0]   map_pos, pm_wpos;
  logic              pm_we;

  logic [CntW-1:0] par, lch, rch, lpos;
  logic [CntW:0]   lw, rw;
  logic            accept, out_load, is_remove, up_swap;

  imh_slot_mem #(.Depth(MAX_ITEMS), .KeyW(KEY_BITS), .AddrW(AddrW)) u_slots (
    .clk_i, .ra_i(ra), .rb_i(rb), .da_o(da), .db_o(db),
    .we_i(we), .wa_i(wa), .wd_i(wd)
  );

  imh_pos_map #(.PosW(CntW)) u_map (
    .clk_i, .rst_ni, .rd_id_i(in_data_i.item_id), .rd_pos_o(map_pos),
    .wr_en_i(pm_we), .wr_id_i(pm_wid), .wr_pos_i(pm_wpos)
  );

  function automatic logic [AddrW-1:0] sa(input logic [CntW-1:0] s);
    logic [CntW-1:0] m;
    m = s - CntW'(1);
    return m[AddrW-1:0];
  endfunction

  function automatic logic [KEY_BITS-1:0] k(input logic [EntW-1:0] e);
    return e[KEY_BITS-1:0];
  endfunction

  function automatic logic [IdBits-1:0] idof(input logic [EntW-1:0] e);
    return e[EntW-1:KEY_BITS];
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // a recorded slot beyond the count counts as absent
  assign lpos      = (map_pos > cnt_q) ? '0 : map_pos;
  assign par       = i_q >> 1;
  assign lw        = {i_q, 1'b0};
  assign rw        = lw + (CntW+1)'(1);
  assign lch       = lw[CntW-1:0];
  assign rch       = rw[CntW-1:0];
  assign is_remove = (req_q.req_type == REQ_REMOVE);
  // remove walks to the root unconditionally
  assign up_swap   = is_remove || (k(da) > k(db));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOOK;
      end
      S_LOOK: begin
        case (req_q.req_type)
          REQ_INSERT: begin
            if (lpos == '0 && cnt_q < CntW'(MAX_ITEMS)) state_d = S_UP_RD;
            else state_d = S_DONE;
          end
          REQ_EXTRACT: state_d = (cnt_q == '0) ? S_DONE : S_TOP_RD;
          REQ_REMOVE:  state_d = (lpos == '0) ? S_DONE : S_UP_RD;
          default:     state_d = S_DONE;
        endcase
      end
      S_UP_RD: begin
        if (i_q > CntW'(1)) state_d = S_UP_CMP;
        else if (is_remove) state_d = S_TOP_RD;
        else state_d = S_DONE;
      end
      S_UP_CMP:   state_d = up_swap ? S_UP_WR : S_DONE;
      S_UP_WR:    state_d = S_UP_RD;
      S_TOP_RD:   state_d = S_TOP_SWAP;
      S_TOP_SWAP: state_d = S_TOP_CLR;
      S_TOP_CLR:  state_d = S_DN_RD;
      S_DN_RD:    state_d = (lw > {1'b0, cnt_q}) ? S_DONE : S_DN_CMP;
      S_DN_CMP:   state_d = (rw <= {1'b0, cnt_q}) ? S_DN_RD2 : S_DN_SWAP;
      S_DN_RD2:   state_d = S_DN_SWAP;
      S_DN_SWAP:  state_d = (best_q == i_q) ? S_DONE : S_DN_WR;
      S_DN_WR:    state_d = S_DN_RD;
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control; each swap writes one slot per cycle
  always_comb begin
    cnt_d = cnt_q; i_d = i_q; ea_d = ea_q; eb_d = eb_q;
    best_d = best_q; st_d = st_q; oid_d = oid_q; okey_d = okey_q; opos_d = opos_q;
    ra = '0; rb = '0; we = 1'b0; wa = '0; wd = '0;
    pm_we = 1'b0; pm_wid = '0; pm_wpos = '0;
    case (state_q)
      S_LOOK: begin
        st_d = ST_OK; oid_d = req_q.item_id; okey_d = '0; opos_d = '0;
        case (req_q.req_type)
          REQ_INSERT: begin
            if (lpos != '0) begin
              st_d = ST_PRESENT;
            end else if (cnt_q >= CntW'(MAX_ITEMS)) begin
              st_d = ST_FULL;
            end else begin
              cnt_d = cnt_q + CntW'(1);
              i_d = cnt_d;
              we = 1'b1; wa = sa(cnt_d);
              wd = {req_q.item_id, KEY_BITS'(req_q.item_key)};
              pm_we = 1'b1; pm_wid = req_q.item_id; pm_wpos = cnt_d;
            end
          end
          REQ_EXTRACT: begin
            if (cnt_q == '0) st_d = ST_EMPTY;
          end
          REQ_REMOVE: begin
            if (lpos == '0) st_d = ST_ABSENT;
            else i_d = lpos;
          end
          default: begin
            opos_d = lpos;
            if (lpos == '0) st_d = ST_ABSENT;
          end
        endcase
      end
      S_UP_RD: begin
        ra = sa((i_q > CntW'(1)) ? par : CntW'(1)); rb = sa(i_q);
      end
      S_UP_CMP: begin
        if (up_swap) begin
          we = 1'b1; wa = sa(i_q); wd = da;
          pm_we = 1'b1; pm_wid = idof(da); pm_wpos = i_q;
          ea_d = db; i_d = par;
        end
      end
      S_UP_WR, S_DN_WR: begin
        we = 1'b1; wa = sa(i_q); wd = ea_q;
        pm_we = 1'b1; pm_wid = idof(ea_q); pm_wpos = i_q;
      end
      S_TOP_RD: begin
        ra = sa(CntW'(1)); rb = sa(cnt_q);
      end
      S_TOP_SWAP: begin
        if (req_q.req_type == REQ_EXTRACT) begin
          oid_d = idof(da); okey_d = k(da);
        end
        // the last entry moves to the root; the old root leaves the heap
        we = 1'b1; wa = sa(CntW'(1)); wd = db;
        pm_we = 1'b1; pm_wid = idof(db); pm_wpos = CntW'(1);
        ea_d = da;
        cnt_d = cnt_q - CntW'(1);
        i_d = CntW'(1);
      end
      S_TOP_CLR: begin
        pm_we = 1'b1; pm_wid = idof(ea_q); pm_wpos = '0;
      end
      S_DN_RD: begin
        ra = sa(i_q); rb = sa((lw > {1'b0, cnt_q}) ? CntW'(1) : lch);
      end
      S_DN_CMP: begin
        ea_d = da; eb_d = db;
        best_d = (k(da) < k(db)) ? i_q : lch;
        ra = sa((rw <= {1'b0, cnt_q}) ? rch : CntW'(1));
      end
      S_DN_RD2: begin
        if (k(da) < ((best_q == i_q) ? k(ea_q) : k(eb_q))) begin
          best_d = rch; eb_d = da;
        end
      end
      S_DN_SWAP: begin
        if (best_q != i_q) begin
          we = 1'b1; wa = sa(i_q); wd = eb_q;
          pm_we = 1'b1; pm_wid = idof(eb_q); pm_wpos = i_q;
          i_d = best_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
    i_q <= i_d; ea_q <= ea_d; eb_q <= eb_d;
    best_q <= best_d; st_q <= st_d; oid_q <= oid_d; okey_q <= okey_d; opos_q <= opos_d;
    if (out_load) begin
      out_q.out_id       <= oid_q;
      out_q.out_key      <= OutKeyBits'(okey_q);
      out_q.out_position <= PosBits'(opos_q);
      out_q.entry_count  <= PosBits'(cnt_q);
      out_q.status       <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o));
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_ITEMS));
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_LOOK) && !in_ready_o);

endmodule
